@@ hdl/kmmma_pkg.sv @@
// Shared types, constants and command/status bundles of the keyed aggregator.
package kmmma_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned USED_W      = $clog2(TABLE_DEPTH + 1);

  localparam int unsigned NUM_SENSORS = 6;
  localparam int unsigned SEN_W       = 3;
  localparam int unsigned DEV_W       = 16;
  localparam int unsigned MONTH_W     = 15;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned SUM_W       = 56;
  localparam int unsigned CNT_W       = 24;
  localparam int unsigned KEY_W       = DEV_W + MONTH_W + SEN_W;

  localparam logic [CNT_W-1:0]   COUNT_MAX       = '1;
  localparam logic [MONTH_W-1:0] FIRST_MONTH_RST = 15'd24290;  // March 2024
  localparam logic [SEN_W-1:0]   LAST_SENSOR     = SEN_W'(NUM_SENSORS - 1);

  typedef enum logic [1:0] {
    ST_UPDATED = 2'd0,
    ST_CREATED = 2'd1,
    ST_FULL    = 2'd2
  } upd_status_e;

  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] max_v;
    logic signed [VAL_W-1:0] min_v;
    logic signed [SUM_W-1:0] sum_v;
    logic [CNT_W-1:0]        cnt_v;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic clr_k;
    logic inc_k;
    logic wr_hit;
    logic wr_new;
    logic div_start;
    logic load_out;
    logic next_sensor;
  } dp_cmd_t;

  typedef struct packed {
    logic              month_ok;
    logic              used_zero;
    logic              key_match;
    logic              k_last;
    logic              full;
    logic              div_done;
    logic              div_busy;
    logic              out_free;
    logic              sen_last;
    logic [USED_W-1:0] used;
  } dp_stat_t;

endpackage

@@ hdl/kmmma_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module kmmma_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hdl/kmmma_div.sv @@
// Bit-serial signed divider: 56-bit sum by 24-bit count, truncated toward zero.
module kmmma_div import kmmma_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [SUM_W-1:0] dividend_i,
  input  logic [CNT_W-1:0]        divisor_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic signed [VAL_W-1:0] quotient_o
);

  localparam int unsigned STEP_W = $clog2(SUM_W);

  logic              busy_q, done_q, neg_q;
  logic [STEP_W-1:0] step_q;
  logic [SUM_W-1:0]  quo_q;
  logic [CNT_W-1:0]  rem_q, dvs_q;
  logic [CNT_W:0]    rem_sh, diff;
  logic [SUM_W-1:0]  mag;

  assign mag    = dividend_i[SUM_W-1] ? (~dividend_i + SUM_W'(1)) : dividend_i;
  assign rem_sh = {rem_q, quo_q[SUM_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};

  // control: run one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(SUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: restoring shift-subtract on the magnitude
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= mag;
      rem_q <= '0;
      dvs_q <= divisor_i;
      neg_q <= dividend_i[SUM_W-1];
    end else if (busy_q) begin
      if (!diff[CNT_W]) begin
        rem_q <= diff[CNT_W-1:0];
        quo_q <= {quo_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[CNT_W-1:0];
        quo_q <= {quo_q[SUM_W-2:0], 1'b0};
      end
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~quo_q[VAL_W-1:0] + VAL_W'(1)) : quo_q[VAL_W-1:0];

endmodule

@@ hdl/kmmma_dp.sv @@
// Datapath: input word, key table, scan counter, divider and output register.
module kmmma_dp import kmmma_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [MONTH_W-1:0]        cfg_wdata_i,
  input  logic                      in_load_i,
  input  logic [DEV_W-1:0]          device_id_i,
  input  logic [MONTH_W-1:0]        month_index_i,
  input  logic signed [VAL_W-1:0]   temperature_i,
  input  logic signed [VAL_W-1:0]   humidity_i,
  input  logic signed [VAL_W-1:0]   light_level_i,
  input  logic signed [VAL_W-1:0]   noise_level_i,
  input  logic signed [VAL_W-1:0]   eco2_level_i,
  input  logic signed [VAL_W-1:0]   voc_level_i,
  input  dp_cmd_t                   cmd_i,
  output dp_stat_t                  stat_o,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [SEN_W-1:0]          sensor_index_o,
  output logic [DEV_W-1:0]          out_device_o,
  output logic [MONTH_W-1:0]        out_month_o,
  output logic signed [VAL_W-1:0]   max_value_o,
  output logic signed [VAL_W-1:0]   min_value_o,
  output logic signed [VAL_W-1:0]   mean_value_o,
  output logic [CNT_W-1:0]          sample_count_o,
  output logic [1:0]                update_status_o,
  output logic                      last_of_record_o
);

  logic [MONTH_W-1:0]      first_month_q;
  logic [DEV_W-1:0]        dev_q;
  logic [MONTH_W-1:0]      month_q;
  logic signed [VAL_W-1:0] val_q [NUM_SENSORS];
  logic [SEN_W-1:0]        sen_q;
  logic [IDX_W-1:0]        k_q;
  logic [USED_W-1:0]       used_q;
  entry_t                  ent_q;
  upd_status_e             status_q;
  logic                    out_valid_q;

  logic signed [VAL_W-1:0] cur_val;
  logic [KEY_W-1:0]        key;
  logic [ENTRY_W-1:0]      rd_raw;
  entry_t                  rd_ent, upd_ent, new_ent, wr_ent;
  logic                    full, sat, ram_we;
  logic [IDX_W-1:0]        waddr;
  logic                    div_busy, div_done;
  logic signed [VAL_W-1:0] div_quo;

  assign cur_val = val_q[sen_q];
  assign key     = {dev_q, month_q, sen_q};
  assign full    = (used_q == USED_W'(TABLE_DEPTH));
  assign rd_ent  = entry_t'(rd_raw);

  // fold the reading into a matching entry; count saturates and freezes the sum
  assign sat = (rd_ent.cnt_v == COUNT_MAX);
  always_comb begin
    upd_ent       = rd_ent;
    upd_ent.max_v = (cur_val > rd_ent.max_v) ? cur_val : rd_ent.max_v;
    upd_ent.min_v = (cur_val < rd_ent.min_v) ? cur_val : rd_ent.min_v;
    if (!sat) begin
      upd_ent.sum_v = rd_ent.sum_v + SUM_W'(cur_val);
      upd_ent.cnt_v = rd_ent.cnt_v + CNT_W'(1);
    end
  end

  // seed a fresh entry from the reading
  always_comb begin
    new_ent.key   = key;
    new_ent.max_v = cur_val;
    new_ent.min_v = cur_val;
    new_ent.sum_v = SUM_W'(cur_val);
    new_ent.cnt_v = CNT_W'(1);
  end

  assign ram_we = cmd_i.wr_hit | (cmd_i.wr_new & ~full);
  assign waddr  = cmd_i.wr_hit ? k_q : IDX_W'(used_q);
  assign wr_ent = cmd_i.wr_hit ? upd_ent : new_ent;

  kmmma_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (wr_ent),
    .raddr_i (k_q),
    .rdata_o (rd_raw)
  );

  kmmma_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (ent_q.sum_v),
    .divisor_i  (ent_q.cnt_v),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // control registers: config, scan index, fill count, sensor, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_month_q <= FIRST_MONTH_RST;
      sen_q         <= '0;
      k_q           <= '0;
      used_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        first_month_q <= cfg_wdata_i;
      end
      if (in_load_i) begin
        sen_q <= '0;
      end else if (cmd_i.next_sensor) begin
        sen_q <= sen_q + SEN_W'(1);
      end
      if (cmd_i.clr_k) begin
        k_q <= '0;
      end else if (cmd_i.inc_k) begin
        k_q <= k_q + IDX_W'(1);
      end
      if (cmd_i.wr_new && !full) begin
        used_q <= used_q + USED_W'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload: input word, working entry, status
  always_ff @(posedge clk_i) begin
    if (in_load_i) begin
      dev_q    <= device_id_i;
      month_q  <= month_index_i;
      val_q[0] <= temperature_i;
      val_q[1] <= humidity_i;
      val_q[2] <= light_level_i;
      val_q[3] <= noise_level_i;
      val_q[4] <= eco2_level_i;
      val_q[5] <= voc_level_i;
    end
    if (ram_we) begin
      ent_q <= wr_ent;
    end
    if (cmd_i.wr_hit) begin
      status_q <= ST_UPDATED;
    end else if (cmd_i.wr_new) begin
      status_q <= full ? ST_FULL : ST_CREATED;
    end
  end

  // output word; a dropped reading reports zeros
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      sensor_index_o   <= sen_q;
      out_device_o     <= dev_q;
      out_month_o      <= month_q;
      update_status_o  <= status_q;
      last_of_record_o <= (sen_q == LAST_SENSOR);
      if (status_q == ST_FULL) begin
        max_value_o    <= '0;
        min_value_o    <= '0;
        mean_value_o   <= '0;
        sample_count_o <= '0;
      end else begin
        max_value_o    <= ent_q.max_v;
        min_value_o    <= ent_q.min_v;
        mean_value_o   <= div_quo;
        sample_count_o <= ent_q.cnt_v;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    stat_o.month_ok  = (month_q >= first_month_q);
    stat_o.used_zero = (used_q == '0);
    stat_o.key_match = (rd_ent.key == key);
    stat_o.k_last    = ((USED_W'(k_q) + USED_W'(1)) == used_q);
    stat_o.full      = full;
    stat_o.div_done  = div_done;
    stat_o.div_busy  = div_busy;
    stat_o.out_free  = ~out_valid_q | out_ready_i;
    stat_o.sen_last  = (sen_q == LAST_SENSOR);
    stat_o.used      = used_q;
  end

endmodule

@@ hdl/kmmma_ctrl.sv @@
// Controller: sequences month check, table scan, update, divide and output per reading.
module kmmma_ctrl import kmmma_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  dp_stat_t stat_i,
  output logic     in_ready_o,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_START, S_READ, S_CMP, S_MISS, S_DIV, S_WAITD, S_OUT
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE:  state_d = in_valid_i ? S_CHECK : S_IDLE;
      S_CHECK: state_d = stat_i.month_ok ? S_START : S_IDLE;
      S_START: begin
        cmd_o.clr_k = 1'b1;
        state_d     = stat_i.used_zero ? S_MISS : S_READ;
      end
      S_READ:  state_d = S_CMP;
      S_CMP: begin
        priority if (stat_i.key_match) begin
          cmd_o.wr_hit = 1'b1;
          state_d      = S_DIV;
        end else if (stat_i.k_last) begin
          state_d = S_MISS;
        end else begin
          cmd_o.inc_k = 1'b1;
          state_d     = S_READ;
        end
      end
      S_MISS: begin
        cmd_o.wr_new = 1'b1;
        state_d      = stat_i.full ? S_OUT : S_DIV;
      end
      S_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_WAITD;
      end
      S_WAITD: state_d = stat_i.div_done ? S_OUT : S_WAITD;
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (stat_i.sen_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.next_sensor = 1'b1;
            state_d           = S_START;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // hold state; leave idle when a word is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

@@ hdl/keyed_min_max_mean_aggregator.sv @@
// Top level of the keyed min/max/mean aggregator.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one record word: device id,
//   month index and six signed readings. Output channel (out_valid_o/
//   out_ready_i) gives six words per record, one per sensor, in sensor order,
//   the last flagged by last_of_record_o. A record with a month index below
//   first_month gives no words. cfg_we_i/cfg_wdata_i write first_month.
//   Each reading scans the key table from entry 0 through one RAM read
//   port, reading and then comparing one entry at a time until a match
//   or the last used entry; the bit-serial divider then computes the
//   mean. When the table is full a new key is not stored and the divider
//   is skipped. One record is in work at a time; the next is taken once
//   the last word of the previous one sits in the output register.
//   Reset empties the table (fill count to zero) and sets first_month to
//   24290; no clearing pass is needed. While the receiver stalls, the output
//   word holds and the controller waits before loading the next one.
module keyed_min_max_mean_aggregator import kmmma_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [MONTH_W-1:0]      cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [DEV_W-1:0]        device_id_i,
  input  logic [MONTH_W-1:0]      month_index_i,
  input  logic signed [VAL_W-1:0] temperature_i,
  input  logic signed [VAL_W-1:0] humidity_i,
  input  logic signed [VAL_W-1:0] light_level_i,
  input  logic signed [VAL_W-1:0] noise_level_i,
  input  logic signed [VAL_W-1:0] eco2_level_i,
  input  logic signed [VAL_W-1:0] voc_level_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [SEN_W-1:0]        sensor_index_o,
  output logic [DEV_W-1:0]        out_device_o,
  output logic [MONTH_W-1:0]      out_month_o,
  output logic signed [VAL_W-1:0] max_value_o,
  output logic signed [VAL_W-1:0] min_value_o,
  output logic signed [VAL_W-1:0] mean_value_o,
  output logic [CNT_W-1:0]        sample_count_o,
  output logic [1:0]              update_status_o,
  output logic                    last_of_record_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_load;

  assign in_load = in_valid_i & in_ready_o;

  kmmma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  kmmma_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_load_i        (in_load),
    .device_id_i      (device_id_i),
    .month_index_i    (month_index_i),
    .temperature_i    (temperature_i),
    .humidity_i       (humidity_i),
    .light_level_i    (light_level_i),
    .noise_level_i    (noise_level_i),
    .eco2_level_i     (eco2_level_i),
    .voc_level_i      (voc_level_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .sensor_index_o   (sensor_index_o),
    .out_device_o     (out_device_o),
    .out_month_o      (out_month_o),
    .max_value_o      (max_value_o),
    .min_value_o      (min_value_o),
    .mean_value_o     (mean_value_o),
    .sample_count_o   (sample_count_o),
    .update_status_o  (update_status_o),
    .last_of_record_o (last_of_record_o)
  );

`ifndef NO_ASSERTIONS
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.used <= USED_W'(TABLE_DEPTH)) else $error("fill count beyond table depth");

  a_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !stat.div_busy) else $error("divider busy while idle");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_record_o |-> sensor_index_o == LAST_SENSOR)
    else $error("last flag on wrong sensor");

  a_take_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("second word taken at once");
`endif

endmodule
